FILE: hdl/pcfbs_pkg.sv
// pcfbs_pkg: shared types, constants and microcode ROM for the p-center
// fitness evaluator. No dependencies.
package pcfbs_pkg;

  localparam int COORD_BITS   = 16;
  localparam int FIT_W        = 2 * COORD_BITS + 1;
  localparam int CAND_MAX_DEF = 8;
  localparam int FAC_MAX_DEF  = 16;

  localparam int FAC_CNT_W  = 5;
  localparam int CAND_CNT_W = 4;
  localparam logic [FAC_CNT_W-1:0]  FAC_CNT_RST  = 5'd16;
  localparam logic [CAND_CNT_W-1:0] CAND_CNT_RST = 4'd8;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-1:0] REG_FAC_COUNT  = 3'h0;
  localparam logic [APB_AW-1:0] REG_CAND_COUNT = 3'h4;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_DEMAND = 1'b1;

  typedef struct packed {
    logic                         func;
    logic [2:0]                   cand_index;
    logic [3:0]                   fac_index;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic                         last_point;
  } req_t;

  typedef struct packed {
    logic [FIT_W-1:0] best_fitness_sq;
    logic [2:0]       best_index;
  } rsp_t;

  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_SCAN,
    OP_NONE,
    OP_SEL_INIT,
    OP_SELECT,
    OP_EMIT
  } uop_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_DEMAND,
    C_SCAN_END,
    C_PIPE_EMPTY,
    C_LAST,
    C_SEL_END,
    C_OUT_FREE
  } ucond_t;

  typedef logic [2:0] ustep_t;

  localparam ustep_t ST_WAIT      = 3'd0;
  localparam ustep_t ST_SCAN      = 3'd1;
  localparam ustep_t ST_DRAIN     = 3'd2;
  localparam ustep_t ST_CHECK     = 3'd3;
  localparam ustep_t ST_SELECT    = 3'd4;
  localparam ustep_t ST_SEL_DRAIN = 3'd5;
  localparam ustep_t ST_EMIT      = 3'd6;

  // cond true -> tgt_t, else tgt_f
  typedef struct packed {
    uop_t   op;
    ucond_t cond;
    ustep_t tgt_t;
    ustep_t tgt_f;
  } ucode_t;

  function automatic ucode_t ucode_rom(input ustep_t s);
    ucode_t w;
    unique case (s)
      ST_WAIT:      w = '{OP_ACCEPT,   C_DEMAND,     ST_SCAN,      ST_WAIT};
      ST_SCAN:      w = '{OP_SCAN,     C_SCAN_END,   ST_DRAIN,     ST_SCAN};
      ST_DRAIN:     w = '{OP_NONE,     C_PIPE_EMPTY, ST_CHECK,     ST_DRAIN};
      ST_CHECK:     w = '{OP_SEL_INIT, C_LAST,       ST_SELECT,    ST_WAIT};
      ST_SELECT:    w = '{OP_SELECT,   C_SEL_END,    ST_SEL_DRAIN, ST_SELECT};
      ST_SEL_DRAIN: w = '{OP_NONE,     C_ALWAYS,     ST_EMIT,      ST_EMIT};
      ST_EMIT:      w = '{OP_EMIT,     C_OUT_FREE,   ST_WAIT,      ST_EMIT};
      default:      w = '{OP_NONE,     C_ALWAYS,     ST_WAIT,      ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/pcenter_fitness_best_select_top.sv
// Input: load words are accepted back to back; a demand point holds off further input while
// the facility store read port scans it (one distance per cycle); the last point also runs
// the best-candidate search and waits until the result register is free.
// Reset (rst, synchronous): sequencer to wait step, counts to 16/8, running maxima read
// as zero; facility store is not cleared.
// Top level: microcoded sequencer, facility store, distance pipeline. Depends on pcfbs_pkg.
module pcenter_fitness_best_select_top #(
  parameter int CAND_MAX = pcfbs_pkg::CAND_MAX_DEF,
  parameter int FAC_MAX  = pcfbs_pkg::FAC_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  pcfbs_pkg::req_t               req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output pcfbs_pkg::rsp_t               rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcfbs_pkg::APB_AW-1:0]  paddr,
  input  logic [pcfbs_pkg::APB_DW-1:0]  pwdata,
  output logic [pcfbs_pkg::APB_DW-1:0]  prdata,
  output logic                          pready
);
  import pcfbs_pkg::*;

  localparam int DEPTH = CAND_MAX * FAC_MAX;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (CAND_MAX > 1) ? $clog2(CAND_MAX) : 1;
  localparam int FW    = (FAC_MAX > 1) ? $clog2(FAC_MAX) : 1;
  localparam int CB    = COORD_BITS;

  // config registers
  logic [FAC_CNT_W-1:0]  fac_count;
  logic [CAND_CNT_W-1:0] cand_count;
  logic [FW-1:0]         f_last;
  logic [CW-1:0]         c_last;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fac_count  <= FAC_CNT_RST;
      cand_count <= CAND_CNT_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr)
        REG_FAC_COUNT:  fac_count  <= pwdata[FAC_CNT_W-1:0];
        REG_CAND_COUNT: cand_count <= pwdata[CAND_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      REG_FAC_COUNT:  prdata = APB_DW'(fac_count);
      REG_CAND_COUNT: prdata = APB_DW'(cand_count);
      default:        prdata = '0;
    endcase
  end

  // zero acts as one, large values saturate
  always_comb begin
    if (fac_count == '0) begin
      f_last = '0;
    end else if (32'(fac_count) > FAC_MAX) begin
      f_last = FW'(FAC_MAX - 1);
    end else begin
      f_last = FW'(32'(fac_count) - 32'd1);
    end
    if (cand_count == '0) begin
      c_last = '0;
    end else if (32'(cand_count) > CAND_MAX) begin
      c_last = CW'(CAND_MAX - 1);
    end else begin
      c_last = CW'(32'(cand_count) - 32'd1);
    end
  end

  // sequencer
  ustep_t step, step_next;
  ucode_t uc;
  logic   cond_ok;
  logic   req_fire;
  logic   demand_fire;
  logic   load_fire;

  logic [CW-1:0] c_cnt;
  logic [FW-1:0] f_cnt;
  logic [AW-1:0] base;
  logic [CW-1:0] sel_c;
  logic          p1_v, p2_v, p3_v, p4_v;
  logic          pt_last;

  assign uc          = ucode_rom(step);
  assign req_stall   = (uc.op != OP_ACCEPT);
  assign req_fire    = req_valid && !req_stall;
  assign demand_fire = req_fire && (req.func == FUNC_DEMAND);
  assign load_fire   = req_fire && (req.func == FUNC_LOAD);

  always_comb begin
    unique case (uc.cond)
      C_ALWAYS:     cond_ok = 1'b1;
      C_DEMAND:     cond_ok = demand_fire;
      C_SCAN_END:   cond_ok = (c_cnt == c_last) && (f_cnt == f_last);
      C_PIPE_EMPTY: cond_ok = !(p1_v || p2_v || p3_v || p4_v);
      C_LAST:       cond_ok = pt_last;
      C_SEL_END:    cond_ok = (sel_c == c_last);
      C_OUT_FREE:   cond_ok = !rsp_valid || !rsp_stall;
      default:      cond_ok = 1'b0;
    endcase
    step_next = cond_ok ? uc.tgt_t : uc.tgt_f;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_WAIT;
    end else begin
      step <= step_next;
    end
  end

  // demand point latch
  logic signed [CB-1:0] px, py;

  always_ff @(posedge clk) begin
    if (demand_fire) begin
      px      <= req.coord_x;
      py      <= req.coord_y;
      pt_last <= req.last_point;
    end
  end

  // facility store: {x, y} per slot
  logic [2*CB-1:0] fac_mem [DEPTH];
  logic [2*CB-1:0] fac_rd;
  logic [AW-1:0]   waddr;
  logic [AW-1:0]   scan_addr;
  logic            w_in_range;

  assign w_in_range = (32'(req.cand_index) < CAND_MAX) && (32'(req.fac_index) < FAC_MAX);
  assign waddr      = AW'(32'(req.cand_index) * FAC_MAX + 32'(req.fac_index));
  assign scan_addr  = AW'(32'(base) + 32'(f_cnt));

  always_ff @(posedge clk) begin
    if (load_fire && w_in_range) begin
      fac_mem[waddr] <= {req.coord_x, req.coord_y};
    end
    fac_rd <= fac_mem[scan_addr];
  end

  // scan counters
  always_ff @(posedge clk) begin
    if (rst) begin
      c_cnt <= '0;
      f_cnt <= '0;
      base  <= '0;
    end else if (uc.op == OP_ACCEPT) begin
      c_cnt <= '0;
      f_cnt <= '0;
      base  <= '0;
    end else if (uc.op == OP_SCAN) begin
      if (f_cnt == f_last) begin
        f_cnt <= '0;
        c_cnt <= c_cnt + CW'(1);
        base  <= AW'(32'(base) + FAC_MAX);
      end else begin
        f_cnt <= f_cnt + FW'(1);
      end
    end
  end

  // distance pipeline
  logic          p1_first, p2_first, p3_first;
  logic          p1_lastf, p2_lastf, p3_lastf;
  logic [CW-1:0] p1_c, p2_c, p3_c, p4_c;

  logic signed [CB:0] ex, ey;
  logic [CB:0]        ax, ay;
  logic [CB-1:0]      p2_dx, p2_dy;
  logic [2*CB-1:0]    p3_sx, p3_sy;
  logic [FIT_W-1:0]   dist_sum;
  logic [FIT_W-1:0]   near;

  assign ex = {px[CB-1], px} - {fac_rd[2*CB-1], fac_rd[2*CB-1:CB]};
  assign ey = {py[CB-1], py} - {fac_rd[CB-1], fac_rd[CB-1:0]};
  assign ax = ex[CB] ? (~ex + 1'b1) : ex;
  assign ay = ey[CB] ? (~ey + 1'b1) : ey;
  assign dist_sum = {1'b0, p3_sx} + {1'b0, p3_sy};

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
      p4_v <= 1'b0;
    end else begin
      p1_v <= (uc.op == OP_SCAN);
      p2_v <= p1_v;
      p3_v <= p2_v;
      p4_v <= p3_v && p3_lastf;
    end
  end

  always_ff @(posedge clk) begin
    p1_first <= (f_cnt == '0);
    p1_lastf <= (f_cnt == f_last);
    p1_c     <= c_cnt;
    p2_first <= p1_first;
    p2_lastf <= p1_lastf;
    p2_c     <= p1_c;
    p2_dx    <= ax[CB-1:0];
    p2_dy    <= ay[CB-1:0];
    p3_first <= p2_first;
    p3_lastf <= p2_lastf;
    p3_c     <= p2_c;
    p3_sx    <= {{CB{1'b0}}, p2_dx} * {{CB{1'b0}}, p2_dx};
    p3_sy    <= {{CB{1'b0}}, p2_dy} * {{CB{1'b0}}, p2_dy};
    p4_c     <= p3_c;
    if (p3_v && (p3_first || (dist_sum < near))) begin
      near <= dist_sum;
    end
  end

  // running maxima store; an entry without its valid bit reads as zero
  logic [FIT_W-1:0]    mx_mem [CAND_MAX];
  logic [CAND_MAX-1:0] mx_ok;
  logic [FIT_W-1:0]    mx_rd;
  logic                mx_rd_ok;
  logic [FIT_W-1:0]    mx_cur;
  logic [CW-1:0]       mx_raddr;
  logic                emit;

  assign mx_raddr = (uc.op == OP_SELECT) ? sel_c : p3_c;
  assign mx_cur   = mx_rd_ok ? mx_rd : '0;
  assign emit     = (uc.op == OP_EMIT) && cond_ok;

  always_ff @(posedge clk) begin
    mx_rd    <= mx_mem[mx_raddr];
    mx_rd_ok <= mx_ok[mx_raddr];
    if (p4_v && (near > mx_cur)) begin
      mx_mem[p4_c] <= near;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mx_ok <= '0;
    end else if (emit) begin
      mx_ok <= '0;
    end else if (p4_v && (near > mx_cur)) begin
      mx_ok[p4_c] <= 1'b1;
    end
  end

  // best-candidate search, ties keep the lower index
  logic             sel_v_d;
  logic             sel_first_d;
  logic [CW-1:0]    sel_idx_d;
  logic [FIT_W-1:0] best;
  logic [CW-1:0]    best_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_c   <= '0;
      sel_v_d <= 1'b0;
    end else begin
      sel_v_d <= (uc.op == OP_SELECT);
      if (uc.op == OP_SEL_INIT) begin
        sel_c <= '0;
      end else if (uc.op == OP_SELECT) begin
        sel_c <= sel_c + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    sel_idx_d   <= sel_c;
    sel_first_d <= (sel_c == '0);
    if (sel_v_d && (sel_first_d || (mx_cur < best))) begin
      best     <= mx_cur;
      best_idx <= sel_idx_d;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.best_fitness_sq <= best;
      rsp.best_index      <= 3'(best_idx);
    end
  end

endmodule

FILE: hdl/pcfbs_checker.sv
// pcfbs_checker: port-level assertions for the p-center fitness evaluator,
// bound to the top level. Depends on pcfbs_pkg.
module pcfbs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_stall,
  input pcfbs_pkg::req_t               req,
  input logic                          rsp_valid,
  input logic                          rsp_stall,
  input pcfbs_pkg::rsp_t               rsp
);
  import pcfbs_pkg::*;

  // held result word
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result word changed while stalled");

  // a load keeps the input side open
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && (req.func == FUNC_LOAD) |=> !req_stall)
    else $error("input stalled after a load word");

  // a demand point starts a scan
  a_demand_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && (req.func == FUNC_DEMAND) |=> req_stall)
    else $error("input open right after a demand point");

  // reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_stall)
    else $error("bad state after reset");

  // a result appears only from the busy sequence
  a_rsp_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("result word while input side was open");

endmodule

bind pcenter_fitness_best_select_top pcfbs_checker u_pcfbs_checker (.*);

FILE: verif/pcenter_fitness_best_select_top_test.sv
`timescale 1ns / 1ps
// Self-checking test of pcenter_fitness_best_select_top: facility loads, demand point
// sets and count registers, predicted in a scoreboard class. Depends on pcfbs_pkg.
module pcenter_fitness_best_select_top_test;
  import pcfbs_pkg::*;

  localparam int SLOTS = CAND_MAX_DEF * FAC_MAX_DEF;

  class fitness_scoreboard;
    logic signed [COORD_BITS-1:0] site_x [SLOTS];
    logic signed [COORD_BITS-1:0] site_y [SLOTS];
    bit                           loaded [SLOTS];
    longint unsigned              worst_sq [CAND_MAX_DEF];
    logic [FAC_CNT_W-1:0]         fac_count;
    logic [CAND_CNT_W-1:0]        cand_count;
    rsp_t                         best_q [$];
    int                           errors;
    int                           loads;
    int                           demands;
    int                           results;

    function new();
      fac_count  = FAC_CNT_RST;
      cand_count = CAND_CNT_RST;
      foreach (worst_sq[c]) worst_sq[c] = 0;
      foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    function int facilities();
      if (fac_count == 0) return 1;
      return (fac_count > FAC_MAX_DEF) ? FAC_MAX_DEF : int'(fac_count);
    endfunction

    function int candidates();
      if (cand_count == 0) return 1;
      return (cand_count > CAND_MAX_DEF) ? CAND_MAX_DEF : int'(cand_count);
    endfunction

    function void write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
      if (addr == REG_FAC_COUNT) fac_count = value[FAC_CNT_W-1:0];
      else if (addr == REG_CAND_COUNT) cand_count = value[CAND_CNT_W-1:0];
    endfunction

    function longint unsigned dist_sq(input logic signed [COORD_BITS-1:0] ax,
                                      input logic signed [COORD_BITS-1:0] ay,
                                      input logic signed [COORD_BITS-1:0] bx,
                                      input logic signed [COORD_BITS-1:0] by);
      longint dx;
      longint dy;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return dx * dx + dy * dy;
    endfunction

    function void note_request(input req_t w);
      int              nf;
      int              nc;
      int              slot;
      int              best_idx;
      longint unsigned nearest;
      longint unsigned d;
      longint unsigned best;
      rsp_t            r;
      if (w.func == FUNC_LOAD) begin
        slot = w.cand_index * FAC_MAX_DEF + w.fac_index;
        site_x[slot] = w.coord_x;
        site_y[slot] = w.coord_y;
        loaded[slot] = 1'b1;
        loads++;
        return;
      end
      demands++;
      nf = facilities();
      nc = candidates();
      for (int c = 0; c < nc; c++) begin
        nearest = dist_sq(w.coord_x, w.coord_y, site_x[c * FAC_MAX_DEF],
                          site_y[c * FAC_MAX_DEF]);
        for (int f = 1; f < nf; f++) begin
          d = dist_sq(w.coord_x, w.coord_y, site_x[c * FAC_MAX_DEF + f],
                      site_y[c * FAC_MAX_DEF + f]);
          if (d < nearest) nearest = d;
        end
        if (nearest > worst_sq[c]) worst_sq[c] = nearest;
      end
      if (!w.last_point) return;
      best = worst_sq[0];
      best_idx = 0;
      for (int c = 1; c < nc; c++) begin
        if (worst_sq[c] < best) begin
          best = worst_sq[c];
          best_idx = c;
        end
      end
      foreach (worst_sq[c]) worst_sq[c] = 0;
      r.best_fitness_sq = best[FIT_W-1:0];
      r.best_index = best_idx[2:0];
      best_q.insert(best_q.size(), r);
    endfunction

    function void check_result(input rsp_t got);
      rsp_t want;
      if (best_q.size() == 0) begin
        $error("result word with none pending: best_fitness_sq %0d best_index %0d",
               got.best_fitness_sq, got.best_index);
        errors++;
        return;
      end
      want = best_q.pop_front();
      results++;
      if (got.best_fitness_sq !== want.best_fitness_sq) begin
        $error("best_fitness_sq: expected %0d, got %0d",
               want.best_fitness_sq, got.best_fitness_sq);
        errors++;
      end
      if (got.best_index !== want.best_index) begin
        $error("best_index: expected %0d, got %0d", want.best_index, got.best_index);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  req_t              req = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  rsp_t              rsp;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  fitness_scoreboard sb;
  bit                steady = 1'b0;

  int fac_plan [8]  = '{16, 31, 1, 16, 5, 3, 8, 12};
  int cand_plan [8] = '{8, 15, 8, 1, 4, 7, 2, 6};

  pcenter_fitness_best_select_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    rsp_stall <= !steady && ($urandom_range(0, 99) < 20);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_result(rsp);
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0:       return 16'sh8000;
        1:       return 16'sh7fff;
        2:       return '0;
        default: return '1;
      endcase
    end
    if (pick < 4) return COORD_BITS'(int'($urandom_range(0, 16)) - 8);
    return COORD_BITS'($urandom);
  endfunction

  function automatic req_t make_word(input logic func, input int c, input int f,
                                     input logic signed [COORD_BITS-1:0] x,
                                     input logic signed [COORD_BITS-1:0] y,
                                     input logic last);
    req_t w;
    w.func       = func;
    w.cand_index = c[2:0];
    w.fac_index  = f[3:0];
    w.coord_x    = x;
    w.coord_y    = y;
    w.last_point = last;
    return w;
  endfunction

  // called just after a falling edge; returns just after the falling edge past acceptance
  task automatic send_word(input req_t w);
    if (!steady && $urandom_range(0, 99) < 20) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(w);
    @(negedge clk);
  endtask

  task automatic send_load(input int c, input int f, input logic signed [COORD_BITS-1:0] x,
                           input logic signed [COORD_BITS-1:0] y, input logic last);
    send_word(make_word(FUNC_LOAD, c, f, x, y, last));
  endtask

  task automatic send_random_load();
    send_load($urandom_range(0, 7), $urandom_range(0, 15), rand_coord(), rand_coord(),
              1'($urandom_range(0, 1)));
  endtask

  // active slots never loaded get filled first, so no unwritten slot is ever scored
  task automatic send_demand(input logic signed [COORD_BITS-1:0] x,
                             input logic signed [COORD_BITS-1:0] y, input logic last);
    for (int c = 0; c < sb.candidates(); c++)
      for (int f = 0; f < sb.facilities(); f++)
        if (!sb.loaded[c * FAC_MAX_DEF + f])
          send_load(c, f, rand_coord(), rand_coord(), 1'b0);
    send_word(make_word(FUNC_DEMAND, $urandom_range(0, 7), $urandom_range(0, 15), x, y, last));
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(addr, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apb_check(input string name, input logic [APB_AW-1:0] addr,
                           input logic [APB_DW-1:0] want);
    logic [APB_DW-1:0] got;
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      sb.errors++;
    end
  endtask

  task automatic configure(input int fac, input int cand);
    apb_write(REG_FAC_COUNT, fac);
    apb_write(REG_CAND_COUNT, cand);
    apb_check("facility_count", REG_FAC_COUNT, APB_DW'(sb.fac_count));
    apb_check("candidate_count", REG_CAND_COUNT, APB_DW'(sb.cand_count));
  endtask

  // quiet point: all results in and the last demand point fully retired
  task automatic settle();
    req_valid <= 1'b0;
    while (sb.best_q.size() != 0) @(posedge clk);
    repeat (160) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_phase(input int words);
    int stop_at;
    int kind;
    int npts;
    stop_at = sb.loads + sb.demands + words;
    while (sb.loads + sb.demands < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        npts = $urandom_range(1, 6);
        for (int i = 0; i < npts; i++) begin
          if ($urandom_range(0, 99) < 15) send_random_load();
          send_demand(rand_coord(), rand_coord(), i == npts - 1);
        end
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 6)) send_random_load();
      end else begin
        send_demand(rand_coord(), rand_coord(), 1'b0);
      end
    end
    send_demand(rand_coord(), rand_coord(), 1'b1);
  endtask

  initial begin
    sb = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    apb_check("facility_count", REG_FAC_COUNT, APB_DW'(FAC_CNT_RST));
    apb_check("candidate_count", REG_CAND_COUNT, APB_DW'(CAND_CNT_RST));

    // zero counts act as one facility, one candidate
    configure(0, 0);
    send_load(0, 0, 16'sh7fff, 16'sh8000, 1'b1);
    send_demand(16'sh8000, 16'sh7fff, 1'b1);
    send_demand(16'sh7fff, 16'sh8000, 1'b1);
    send_demand(16'sh0000, 16'sh0000, 1'b0);
    send_demand(16'shffff, 16'shffff, 1'b0);
    send_demand(16'sh7fff, 16'sh7fff, 1'b1);
    send_load(7, 15, 16'shffff, 16'sh0000, 1'b0);
    settle();

    // equal maxima go to the lower index
    configure(2, 3);
    send_load(0, 0, 16'sd0, 16'sd0, 1'b0);
    send_load(0, 1, 16'sd100, 16'sd100, 1'b0);
    send_load(1, 0, 16'sd100, 16'sd100, 1'b0);
    send_load(1, 1, 16'sd0, 16'sd0, 1'b0);
    send_load(2, 0, 16'sd50, 16'sd50, 1'b0);
    send_load(2, 1, -16'sd50, -16'sd50, 1'b0);
    send_demand(16'sd0, 16'sd0, 1'b0);
    send_demand(16'sd100, 16'sd100, 1'b1);
    send_demand(16'sd200, 16'sd200, 1'b1);
    send_demand(-16'sd50, -16'sd50, 1'b1);
    settle();

    for (int p = 0; p < 10; p++) begin
      steady = (p == 4);
      if (p < 8) configure(fac_plan[p], cand_plan[p]);
      else configure($urandom_range(0, 31), $urandom_range(0, 15));
      run_phase(170);
      settle();
    end
    steady = 1'b0;

    $display("Checked %0d results from %0d facility loads and %0d demand points,",
             sb.results, sb.loads, sb.demands);
    $display("over 12 count settings incl. zero and saturating ones, with stalls both sides.");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
